/* rtl/bee_pkg.sv */
`timescale 1ns / 1ps

package bee_pkg;

    localparam int  MaxChars           = 6;
    localparam bit  JSON_ESCAPE_SOLIDUS = 1'b0;

    typedef enum logic [1:0] {
        STYLE_C     = 2'd0,
        STYLE_JSON  = 2'd1,
        STYLE_CARET = 2'd2,
        STYLE_NAMES = 2'd3
    } t_style;

    typedef logic [7:0] t_char;

    typedef struct packed {
        logic [MaxChars-1:0][7:0] chars;  // chars[0] goes out first
        logic [2:0]               len;
    } t_seq;

    typedef struct packed {
        logic [23:0] text;                // first char in [23:16]
        logic        three;               // 1: three chars, else two
    } t_name;

    localparam t_char CH_BSL   = 8'h5C;
    localparam t_char CH_DQ    = 8'h22;
    localparam t_char CH_SQ    = 8'h27;
    localparam t_char CH_SLASH = 8'h2F;
    localparam t_char CH_CARET = 8'h5E;
    localparam t_char CH_LT    = 8'h3C;
    localparam t_char CH_GT    = 8'h3E;
    localparam t_char CH_ZERO  = 8'h30;
    localparam t_char CH_U     = 8'h75;
    localparam t_char CH_NUL   = 8'h00;

    function automatic t_char hex_digit(input logic [3:0] nib);
        t_char c;
        if (nib < 4'd10) begin
            c = CH_ZERO + {4'h0, nib};
        end else begin
            c = 8'h61 + {4'h0, nib} - 8'd10;
        end
        return c;
    endfunction

    function automatic t_name ctl_name(input logic [5:0] k);
        t_name n;
        case (k)
            6'd0:    n = '{"NUL", 1'b1};
            6'd1:    n = '{"SOH", 1'b1};
            6'd2:    n = '{"STX", 1'b1};
            6'd3:    n = '{"ETX", 1'b1};
            6'd4:    n = '{"EOT", 1'b1};
            6'd5:    n = '{"ENQ", 1'b1};
            6'd6:    n = '{"ACK", 1'b1};
            6'd7:    n = '{"BEL", 1'b1};
            6'd8:    n = '{{"BS", CH_NUL}, 1'b0};
            6'd9:    n = '{{"HT", CH_NUL}, 1'b0};
            6'd10:   n = '{{"LF", CH_NUL}, 1'b0};
            6'd11:   n = '{{"VT", CH_NUL}, 1'b0};
            6'd12:   n = '{{"FF", CH_NUL}, 1'b0};
            6'd13:   n = '{{"CR", CH_NUL}, 1'b0};
            6'd14:   n = '{{"SO", CH_NUL}, 1'b0};
            6'd15:   n = '{{"SI", CH_NUL}, 1'b0};
            6'd16:   n = '{"DLE", 1'b1};
            6'd17:   n = '{"DC1", 1'b1};
            6'd18:   n = '{"DC2", 1'b1};
            6'd19:   n = '{"DC3", 1'b1};
            6'd20:   n = '{"DC4", 1'b1};
            6'd21:   n = '{"NAK", 1'b1};
            6'd22:   n = '{"SYN", 1'b1};
            6'd23:   n = '{"ETB", 1'b1};
            6'd24:   n = '{"CAN", 1'b1};
            6'd25:   n = '{{"EM", CH_NUL}, 1'b0};
            6'd26:   n = '{"SUB", 1'b1};
            6'd27:   n = '{"ESC", 1'b1};
            6'd28:   n = '{{"FS", CH_NUL}, 1'b0};
            6'd29:   n = '{{"GS", CH_NUL}, 1'b0};
            6'd30:   n = '{{"RS", CH_NUL}, 1'b0};
            6'd31:   n = '{{"US", CH_NUL}, 1'b0};
            6'd32:   n = '{"DEL", 1'b1};
            default: n = '{"DEL", 1'b1};
        endcase
        return n;
    endfunction

endpackage

/* rtl/bee_encode.sv */
`timescale 1ns / 1ps

module bee_encode (
    input  logic [7:0]    i_byte,
    input  bee_pkg::t_style i_style,
    output bee_pkg::t_seq o_seq
);
    import bee_pkg::*;

    logic  ctl;
    t_char letter;
    t_name name;
    logic [5:0] name_idx;

    assign ctl      = (i_byte < 8'd32) || (i_byte == 8'd127);
    assign name_idx = (i_byte == 8'd127) ? 6'd32 : {1'b0, i_byte[4:0]};
    assign name     = ctl_name(name_idx);

    always_comb begin
        letter = CH_NUL;
        case (i_style)
            STYLE_C: begin
                case (i_byte)
                    8'd7:    letter = "a";
                    8'd8:    letter = "b";
                    8'd9:    letter = "t";
                    8'd10:   letter = "n";
                    8'd11:   letter = "v";
                    8'd12:   letter = "f";
                    8'd13:   letter = "r";
                    8'd27:   letter = "e";
                    CH_SQ:   letter = CH_SQ;
                    CH_DQ:   letter = CH_DQ;
                    CH_BSL:  letter = CH_BSL;
                    default: letter = CH_NUL;
                endcase
            end
            STYLE_JSON: begin
                case (i_byte)
                    CH_DQ:   letter = CH_DQ;
                    CH_BSL:  letter = CH_BSL;
                    8'd8:    letter = "b";
                    8'd12:   letter = "f";
                    8'd10:   letter = "n";
                    8'd13:   letter = "r";
                    8'd9:    letter = "t";
                    CH_SLASH: letter = JSON_ESCAPE_SOLIDUS ? CH_SLASH : CH_NUL;
                    default: letter = CH_NUL;
                endcase
            end
            default: letter = CH_NUL;
        endcase
    end

    always_comb begin
        o_seq = '0;
        if (letter != CH_NUL) begin
            o_seq.chars[0] = CH_BSL;
            o_seq.chars[1] = letter;
            o_seq.len      = 3'd2;
        end else if (i_style == STYLE_CARET && ctl) begin
            o_seq.chars[0] = CH_CARET;
            o_seq.chars[1] = i_byte ^ 8'h40;
            o_seq.len      = 3'd2;
        end else if (i_style == STYLE_NAMES && ctl) begin
            o_seq.chars[0] = CH_LT;
            o_seq.chars[1] = name.text[23:16];
            o_seq.chars[2] = name.text[15:8];
            if (name.three) begin
                o_seq.chars[3] = name.text[7:0];
                o_seq.chars[4] = CH_GT;
                o_seq.len      = 3'd5;
            end else begin
                o_seq.chars[3] = CH_GT;
                o_seq.len      = 3'd4;
            end
        end else if (i_byte >= 8'h20 && i_byte <= 8'h7E) begin
            o_seq.chars[0] = i_byte;
            o_seq.len      = 3'd1;
        end else if (i_style == STYLE_JSON) begin
            o_seq.chars[0] = CH_BSL;
            o_seq.chars[1] = CH_U;
            o_seq.chars[2] = CH_ZERO;
            o_seq.chars[3] = CH_ZERO;
            o_seq.chars[4] = hex_digit(i_byte[7:4]);
            o_seq.chars[5] = hex_digit(i_byte[3:0]);
            o_seq.len      = 3'd6;
        end else begin
            o_seq.chars[0] = CH_BSL;
            o_seq.chars[1] = CH_ZERO + {6'd0, i_byte[7:6]};
            o_seq.chars[2] = CH_ZERO + {5'd0, i_byte[5:3]};
            o_seq.chars[3] = CH_ZERO + {5'd0, i_byte[2:0]};
            o_seq.len      = 3'd4;
        end
    end

endmodule

/* rtl/bee_serializer.sv */
`timescale 1ns / 1ps

module bee_serializer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  bee_pkg::t_seq i_seq,
    output logic          o_busy,
    output logic [7:0]    o_char,
    output logic          o_last,
    output logic          o_strobe
);
    import bee_pkg::*;

    logic [MaxChars-1:0][7:0] r_chars, n_chars;
    logic [2:0]               r_cnt, n_cnt;
    logic [7:0]               r_char;
    logic                     r_last, r_strobe;

    // free to load once at most one char is left: it leaves this cycle
    assign o_busy = (r_cnt > 3'd1);

    always_comb begin
        n_chars = {CH_NUL, r_chars[MaxChars-1:1]};
        n_cnt   = (r_cnt != 3'd0) ? r_cnt - 3'd1 : 3'd0;
        if (i_load) begin
            n_chars = i_seq.chars;
            n_cnt   = i_seq.len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chars <= n_chars;
        r_char  <= r_chars[0];
        r_last  <= (r_cnt == 3'd1);
        if (!i_rst_n) begin
            r_cnt    <= 3'd0;
            r_strobe <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_strobe <= (r_cnt != 3'd0);
        end
    end

    assign o_char   = r_char;
    assign o_last   = r_last;
    assign o_strobe = r_strobe;

endmodule

/* rtl/byte_escape_encoder.sv */
`timescale 1ns / 1ps
// Each item is loaded into the char buffer at the edge that takes it; its first char then moves
// to the char output register, which strobes it for the receiver to accept.
// Throughput: one output char per cycle; an item has 1 to 6 chars in its escape, and a new
// item can be taken as the last char of the previous one leaves the char buffer.
// Receiver cannot stall; o_strobe marks each char for one cycle.
// Reset (synchronous, active low) empties the char buffer and sets style to C.
module byte_escape_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_escape_style_we,
    input  logic [1:0] i_escape_style,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_in_byte,
    output logic       o_strobe,
    output logic [7:0] o_out_char,
    output logic       o_last_char
);
    import bee_pkg::*;

    t_style r_escape_style;
    t_seq   enc_seq;
    logic   load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_style <= STYLE_C;
        end else if (i_escape_style_we) begin
            r_escape_style <= t_style'(i_escape_style);
        end
    end

    assign load = start && !busy;

    bee_encode u_encode (
        .i_byte  (i_in_byte),
        .i_style (r_escape_style),
        .o_seq   (enc_seq)
    );

    bee_serializer u_serializer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_seq    (enc_seq),
        .o_busy   (busy),
        .o_char   (o_out_char),
        .o_last   (o_last_char),
        .o_strobe (o_strobe)
    );

endmodule
